[sv/lle_pkg.sv]
// ----------------------------------------------------------------------------
// lle_pkg
// Shared widths, command and status codes, and the controller/datapath
// handshake structures of the linked-list engine.
// ----------------------------------------------------------------------------
package lle_pkg;

    // Default size of the node pool
    localparam int POOL_NODES_DEF = 64;

    // Field widths of the stream payloads
    localparam int COMMAND_W  = 3;
    localparam int DATA_W     = 32;
    localparam int POSITION_W = 7;
    localparam int STATUS_W   = 2;
    localparam int SUM_W      = 40;
    localparam int LENGTH_W   = 7;

    // Packed payload widths, rounded up to whole bytes
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 56;

    // Command codes
    localparam logic [COMMAND_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [COMMAND_W-1:0] CMD_PUSH   = 3'd1;
    localparam logic [COMMAND_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [COMMAND_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [COMMAND_W-1:0] CMD_SUM    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Source of the link written into a freshly taken node
    typedef enum logic [1:0] {
        LINK_NULL,
        LINK_HEAD,
        LINK_SAVED
    } link_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                accept;      // latch input transaction
        logic                walk_start;  // cursor to head, read head
        logic                walk_step;   // cursor to successor, read it
        logic                acc_en;      // add current value to the sum
        logic                rd_free;     // read the free-list head
        logic                alloc_mark;  // take a never-used node
        logic                alloc_free;  // take the free-list head
        logic                place;       // write value and link of new node
        link_sel_t           link_sel;
        logic                head_alloc;  // new node becomes the head
        logic                link_tail;   // link cursor node to new node
        logic                save_found;  // keep link of matched node
        logic                unlink;      // bypass the matched node
        logic                free_found;  // return matched node to free list
        logic                count_inc;
        logic                count_dec;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                load_out;    // move result to output register
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [COMMAND_W-1:0] cmd;
        logic                 head_null;
        logic                 free_avail;
        logic                 mark_avail;
        logic                 link_null;  // successor of cursor is null
        logic                 key_match;  // cursor value equals key
        logic                 last_step;  // walk bound reached
        logic                 out_busy;   // output register still held
    } stat_t;

endpackage

[sv/lle_ctrl.sv]
// ----------------------------------------------------------------------------
// lle_ctrl
// Command sequencer: decodes each command and steps the datapath through
// node allocation, list walks and pointer updates.
// ----------------------------------------------------------------------------
module lle_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  lle_pkg::stat_t st,
    output lle_pkg::ctrl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE,
        S_TAKE_WAIT,
        S_PLACE,
        S_WALK,
        S_LINK_PREV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.link_sel = lle_pkg::LINK_NULL;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (st.cmd) inside
                    lle_pkg::CMD_APPEND, lle_pkg::CMD_PUSH: begin
                        state_next = S_TAKE;
                    end
                    lle_pkg::CMD_INSERT, lle_pkg::CMD_DELETE, lle_pkg::CMD_SUM: begin
                        if (st.head_null) begin
                            ctl.set_status = 1'b1;
                            ctl.status     = lle_pkg::ST_EMPTY;
                            state_next     = S_FINISH;
                        end else begin
                            ctl.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    default: begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            // Pick a node: free list first, then the never-used region
            S_TAKE: begin
                if (st.free_avail) begin
                    ctl.rd_free = 1'b1;
                    state_next  = S_TAKE_WAIT;
                end else if (st.mark_avail) begin
                    ctl.alloc_mark = 1'b1;
                    state_next     = S_PLACE;
                end else begin
                    ctl.set_status = 1'b1;
                    ctl.status     = lle_pkg::ST_FULL;
                    state_next     = S_FINISH;
                end
            end
            S_TAKE_WAIT: begin
                ctl.alloc_free = 1'b1;
                state_next     = S_PLACE;
            end
            // Write the new node and hook it in
            S_PLACE: begin
                ctl.place = 1'b1;
                unique case (st.cmd)
                    lle_pkg::CMD_PUSH: begin
                        ctl.link_sel   = lle_pkg::LINK_HEAD;
                        ctl.head_alloc = 1'b1;
                        ctl.count_inc  = 1'b1;
                        state_next     = S_FINISH;
                    end
                    lle_pkg::CMD_INSERT: begin
                        ctl.link_sel = lle_pkg::LINK_SAVED;
                        state_next   = S_LINK_PREV;
                    end
                    default: begin
                        ctl.link_sel = lle_pkg::LINK_NULL;
                        if (st.head_null) begin
                            ctl.head_alloc = 1'b1;
                            ctl.count_inc  = 1'b1;
                            state_next     = S_FINISH;
                        end else begin
                            ctl.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                endcase
            end
            // One node per cycle along the list
            S_WALK: begin
                unique case (st.cmd) inside
                    lle_pkg::CMD_INSERT, lle_pkg::CMD_DELETE: begin
                        if (st.key_match) begin
                            if (st.cmd == lle_pkg::CMD_INSERT) begin
                                ctl.save_found = 1'b1;
                                state_next     = S_TAKE;
                            end else begin
                                ctl.unlink = 1'b1;
                                state_next = S_LINK_PREV;
                            end
                        end else if (st.link_null || st.last_step) begin
                            ctl.set_status = 1'b1;
                            ctl.status     = lle_pkg::ST_MISSING;
                            state_next     = S_FINISH;
                        end else begin
                            ctl.walk_step = 1'b1;
                        end
                    end
                    lle_pkg::CMD_SUM: begin
                        ctl.acc_en = 1'b1;
                        if (st.link_null || st.last_step) begin
                            state_next = S_FINISH;
                        end else begin
                            ctl.walk_step = 1'b1;
                        end
                    end
                    default: begin
                        // append: stop at the tail and link the new node
                        if (st.link_null || st.last_step) begin
                            ctl.link_tail = 1'b1;
                            ctl.count_inc = 1'b1;
                            state_next    = S_FINISH;
                        end else begin
                            ctl.walk_step = 1'b1;
                        end
                    end
                endcase
            end
            // Final pointer write of insert, or release of a deleted node
            S_LINK_PREV: begin
                if (st.cmd == lle_pkg::CMD_INSERT) begin
                    ctl.link_tail = 1'b1;
                    ctl.count_inc = 1'b1;
                end else begin
                    ctl.free_found = 1'b1;
                    ctl.count_dec  = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!st.out_busy) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/lle_dp.sv]
// ----------------------------------------------------------------------------
// lle_dp
// Datapath: node pool memories, list and free-list pointers, walk cursor,
// suffix-sum accumulator and the result output register.
// ----------------------------------------------------------------------------
module lle_dp #(
    parameter int POOL_NODES = lle_pkg::POOL_NODES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lle_pkg::ctrl_t                    ctl,
    output lle_pkg::stat_t                    st,
    input  logic [lle_pkg::COMMAND_W-1:0]     in_command,
    input  logic signed [lle_pkg::DATA_W-1:0] in_key,
    input  logic signed [lle_pkg::DATA_W-1:0] in_value,
    input  logic [lle_pkg::POSITION_W-1:0]    in_position,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [lle_pkg::STATUS_W-1:0]      out_status,
    output logic signed [lle_pkg::SUM_W-1:0]  out_suffix_sum,
    output logic [lle_pkg::LENGTH_W-1:0]      out_length
);

    // Pointer holds a node index or the null code POOL_NODES
    localparam int PW = $clog2(POOL_NODES + 1);
    localparam int AW = $clog2(POOL_NODES);
    localparam int CW = (PW > lle_pkg::POSITION_W) ? PW : lle_pkg::POSITION_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(POOL_NODES);
    localparam logic [PW-1:0] LAST_STEP = PW'(POOL_NODES - 1);

    // Node pool
    logic [lle_pkg::DATA_W-1:0] value_mem [POOL_NODES];
    logic [PW-1:0]              link_mem  [POOL_NODES];

    logic [lle_pkg::DATA_W-1:0]    rd_val_reg;
    logic [PW-1:0]                 rd_link_reg;
    logic [PW-1:0]                 head_reg, free_reg, mark_reg, count_reg;
    logic [PW-1:0]                 alloc_reg, cur_reg, prev_reg, steps_reg, link_save_reg;
    logic [lle_pkg::COMMAND_W-1:0] cmd_reg;
    logic [lle_pkg::DATA_W-1:0]    key_reg, val_reg;
    logic [lle_pkg::POSITION_W-1:0] pos_reg;
    logic signed [lle_pkg::SUM_W-1:0] acc_reg;
    logic [lle_pkg::STATUS_W-1:0]  status_reg;
    logic                          out_valid_reg;
    logic [lle_pkg::STATUS_W-1:0]  out_status_reg;
    logic signed [lle_pkg::SUM_W-1:0] out_sum_reg;
    logic [lle_pkg::LENGTH_W-1:0]  out_len_reg;

    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          lw_en;
    logic [PW-1:0] lw_addr, lw_data, new_link;
    logic          prev_null, pos_reached;

    assign prev_null   = (prev_reg >= NULL_PTR);
    assign pos_reached = (CW'(steps_reg) >= CW'(pos_reg));

    // Read port address
    always_comb begin
        rd_en   = ctl.walk_start | ctl.walk_step | ctl.rd_free;
        rd_addr = head_reg;
        if (ctl.walk_step) begin
            rd_addr = rd_link_reg;
        end else if (ctl.rd_free) begin
            rd_addr = free_reg;
        end
    end

    // Link to store in a newly taken node
    always_comb begin
        case (ctl.link_sel)
            lle_pkg::LINK_HEAD:  new_link = head_reg;
            lle_pkg::LINK_SAVED: new_link = link_save_reg;
            default:             new_link = NULL_PTR;
        endcase
    end

    // Link write port, at most one source per cycle
    always_comb begin
        lw_en   = 1'b0;
        lw_addr = alloc_reg;
        lw_data = new_link;
        if (ctl.place) begin
            lw_en = 1'b1;
        end else if (ctl.link_tail) begin
            lw_en   = 1'b1;
            lw_addr = cur_reg;
            lw_data = alloc_reg;
        end else if (ctl.unlink && !prev_null) begin
            lw_en   = 1'b1;
            lw_addr = prev_reg;
            lw_data = rd_link_reg;
        end else if (ctl.free_found) begin
            lw_en   = 1'b1;
            lw_addr = cur_reg;
            lw_data = free_reg;
        end
    end

    // Pool memories with registered read data
    always_ff @(posedge aclk) begin
        if (lw_en) begin
            link_mem[lw_addr[AW-1:0]] <= lw_data;
        end
        if (ctl.place) begin
            value_mem[alloc_reg[AW-1:0]] <= val_reg;
        end
        if (rd_en) begin
            rd_val_reg  <= value_mem[rd_addr[AW-1:0]];
            rd_link_reg <= link_mem[rd_addr[AW-1:0]];
        end
    end

    // List control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= NULL_PTR;
            free_reg      <= NULL_PTR;
            mark_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctl.head_alloc) begin
                head_reg <= alloc_reg;
            end else if (ctl.unlink && prev_null) begin
                head_reg <= rd_link_reg;
            end
            if (ctl.alloc_free) begin
                free_reg <= rd_link_reg;
            end else if (ctl.free_found) begin
                free_reg <= cur_reg;
            end
            if (ctl.alloc_mark) begin
                mark_reg <= mark_reg + PW'(1);
            end
            if (ctl.count_inc) begin
                count_reg <= count_reg + PW'(1);
            end else if (ctl.count_dec && (count_reg != '0)) begin
                count_reg <= count_reg - PW'(1);
            end
            if (ctl.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command, cursor, accumulator and result payload
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg    <= in_command;
            key_reg    <= in_key;
            val_reg    <= in_value;
            pos_reg    <= in_position;
            acc_reg    <= '0;
            status_reg <= lle_pkg::ST_OK;
        end else begin
            if (ctl.set_status) begin
                status_reg <= ctl.status;
            end
            if (ctl.acc_en && pos_reached) begin
                acc_reg <= acc_reg + {{(lle_pkg::SUM_W - lle_pkg::DATA_W){rd_val_reg[31]}},
                                      rd_val_reg};
            end
        end
        if (ctl.alloc_mark) begin
            alloc_reg <= mark_reg;
        end else if (ctl.alloc_free) begin
            alloc_reg <= free_reg;
        end
        if (ctl.walk_start) begin
            cur_reg   <= head_reg;
            prev_reg  <= NULL_PTR;
            steps_reg <= '0;
        end else if (ctl.walk_step) begin
            cur_reg   <= rd_link_reg;
            prev_reg  <= cur_reg;
            steps_reg <= steps_reg + PW'(1);
        end
        if (ctl.save_found) begin
            link_save_reg <= rd_link_reg;
        end
        if (ctl.load_out) begin
            out_status_reg <= status_reg;
            out_sum_reg    <= acc_reg;
            out_len_reg    <= lle_pkg::LENGTH_W'(count_reg);
        end
    end

    // Status toward the controller
    always_comb begin
        st.cmd        = cmd_reg;
        st.head_null  = (head_reg >= NULL_PTR);
        st.free_avail = (free_reg < NULL_PTR);
        st.mark_avail = (mark_reg < NULL_PTR);
        st.link_null  = (rd_link_reg >= NULL_PTR);
        st.key_match  = (rd_val_reg == key_reg);
        st.last_step  = (steps_reg == LAST_STEP);
        st.out_busy   = out_valid_reg & ~m_tready;
    end

    assign m_tvalid       = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_suffix_sum = out_sum_reg;
    assign out_length     = out_len_reg;

endmodule

[sv/linked_list_engine_top.sv]
// ----------------------------------------------------------------------------
// linked_list_engine_top
// Singly linked list of signed 32-bit values in a node pool with free list.
// The time from accept to result grows with each list node walked, set by
// the node-by-node walk through the pool memory read port.
// Throughput: one command at a time; the next command is accepted in the
// cycle after the result is loaded, and a stalled result holds the engine
// in its final state.
// Reset (aresetn low, synchronous) empties the list and the pool at once.
// ----------------------------------------------------------------------------
module linked_list_engine_top #(
    parameter int POOL_NODES = lle_pkg::POOL_NODES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[2:0], key[34:3], value[66:35], position[73:67], zero pad
    input  logic [lle_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[1:0], suffix_sum[41:2], length[48:42], zero pad
    output logic [lle_pkg::M_DATA_W-1:0]    m_tdata
);

    lle_pkg::ctrl_t ctl;
    lle_pkg::stat_t st;

    logic [lle_pkg::STATUS_W-1:0]     out_status;
    logic signed [lle_pkg::SUM_W-1:0] out_suffix_sum;
    logic [lle_pkg::LENGTH_W-1:0]     out_length;

    lle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctl      (ctl)
    );

    lle_dp #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .st             (st),
        .in_command     (s_tdata[2:0]),
        .in_key         (s_tdata[34:3]),
        .in_value       (s_tdata[66:35]),
        .in_position    (s_tdata[73:67]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .out_status     (out_status),
        .out_suffix_sum (out_suffix_sum),
        .out_length     (out_length)
    );

    // Result packing
    assign m_tdata = {7'd0, out_length, out_suffix_sum, out_status};

endmodule
